[hdl/rfai_pkg.sv]
// ============================================================================
// rfai_pkg - shared types and constants for the register file ALU core
// Opcodes, result kinds, controller states and the command/status bundles
// that run between the controller and the datapath.
// ============================================================================
package rfai_pkg;

    localparam int DEF_NUM_REGS   = 8;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int OPCODE_W = 3;
    localparam int IDX_W    = 3;
    localparam int IMM_W    = 32;
    localparam int KIND_W   = 2;
    localparam int VAL_W    = 32;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD    = 3'd0,
        OP_CLEAR   = 3'd1,
        OP_ADD     = 3'd2,
        OP_SUB     = 3'd3,
        OP_MUL     = 3'd4,
        OP_DIV     = 3'd5,
        OP_PRINT   = 3'd6,
        OP_INVALID = 3'd7
    } t_opcode;

    typedef enum logic [KIND_W-1:0] {
        KIND_PRINT    = 2'd0,
        KIND_DIV_ZERO = 2'd1,
        KIND_BAD_OP   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ITER,
        ST_FINISH,
        ST_HALT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic  capture;     // latch instruction, read both source registers
        logic  wr_alu;      // write combinational ALU result (load/clear/add/sub)
        logic  iter_start;  // load the shift-add / restoring-divide unit
        logic  iter_en;     // advance the iterative unit by one bit
        logic  wr_iter;     // write multiply or divide result
        logic  out_load;    // fill the result register
        t_kind out_kind;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_opcode op;
        logic    div_zero;
        logic    iter_done;
        logic    out_busy;
    } t_dp_sts;

endpackage

[hdl/rfai_if.sv]
// ============================================================================
// rfai_if - instruction and result channels
// Valid/ready channels; a transfer happens on a rising edge with both high.
// ============================================================================
interface rfai_instr_if;
    import rfai_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [IDX_W-1:0]    src_a;
    logic [IDX_W-1:0]    src_b;
    logic [IDX_W-1:0]    dest;
    logic [IMM_W-1:0]    immediate;

    modport source (output valid, opcode, src_a, src_b, dest, immediate, input ready);
    modport sink   (input valid, opcode, src_a, src_b, dest, immediate, output ready);
endinterface

interface rfai_result_if;
    import rfai_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  reg_index;
    logic [VAL_W-1:0]  value;

    modport source (output valid, kind, reg_index, value, input ready);
    modport sink   (input valid, kind, reg_index, value, output ready);
endinterface

[hdl/register_file_alu_interpreter_core.sv]
// ============================================================================
// register_file_alu_interpreter_core - register file with integer ALU
// Runs one decoded instruction per transfer against NUM_REGS signed registers.
// ============================================================================
// Each instruction transfer runs to completion before the next is taken.
// Load, clear, add and subtract are accepted, then executed and written
// back. Print and the error results follow the same steps, and also wait
// while the result register stays full because the downstream side holds
// ready low; the result register lets the next instruction enter while a
// printed value still waits. Multiply and divide go through one shared
// iterative unit that retires one bit per cycle: accept, load the unit,
// DATA_WIDTH steps, write back. Divide uses magnitudes and fixes the sign on
// write back, so the most negative value divided by minus one wraps to
// itself. A division by zero or an invalid opcode returns one error result
// and halts the core: from then on every instruction is taken at one per
// cycle and dropped until reset. Register fields wrap modulo NUM_REGS.
// Registers read as zero after reset.
module register_file_alu_interpreter_core #(
    parameter int NUM_REGS   = rfai_pkg::DEF_NUM_REGS,
    parameter int DATA_WIDTH = rfai_pkg::DEF_DATA_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rfai_instr_if.sink    i_instr,
    rfai_result_if.source o_result
);
    import rfai_pkg::*;

    // Command and status bundles between the sequencer and the datapath
    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    instr_ready;

    assign i_instr.ready = instr_ready;

    // Sequencer: hold ready in idle and halt, advance through execution
    rfai_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_instr_valid (i_instr.valid),
        .o_instr_ready (instr_ready),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    // Datapath: register file, ALU, iterative unit and result register
    rfai_dp #(
        .NUM_REGS   (NUM_REGS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_opcode    (i_instr.opcode),
        .i_src_a     (i_instr.src_a),
        .i_src_b     (i_instr.src_b),
        .i_dest      (i_instr.dest),
        .i_immediate (i_instr.immediate),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_result    (o_result)
    );

endmodule

[hdl/rfai_ctrl.sv]
// ============================================================================
// rfai_ctrl - instruction sequencer
// Accepts an instruction, dispatches it to the datapath, runs the iterative
// unit for multiply and divide, and parks in a halt state after an error.
// ============================================================================
module rfai_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_instr_valid,
    output logic              o_instr_ready,
    input  rfai_pkg::t_dp_sts i_sts,
    output rfai_pkg::t_dp_cmd o_cmd
);
    import rfai_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_instr_valid) begin
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (i_sts.op) inside
                    OP_LOAD, OP_CLEAR, OP_ADD, OP_SUB: begin
                        n_state = ST_IDLE;
                    end
                    OP_MUL: begin
                        n_state = ST_ITER;
                    end
                    OP_DIV: begin
                        if (!i_sts.div_zero) begin
                            n_state = ST_ITER;
                        end else if (!i_sts.out_busy) begin
                            n_state = ST_HALT;
                        end
                    end
                    OP_PRINT: begin
                        if (!i_sts.out_busy) begin
                            n_state = ST_IDLE;
                        end
                    end
                    OP_INVALID: begin
                        if (!i_sts.out_busy) begin
                            n_state = ST_HALT;
                        end
                    end
                endcase
            end
            ST_ITER: begin
                if (i_sts.iter_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_state = ST_IDLE;
            end
            ST_HALT: begin
                n_state = ST_HALT;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_instr_ready = 1'b0;
        o_cmd         = '0;
        o_cmd.out_kind = KIND_PRINT;
        unique case (r_state)
            ST_IDLE: begin
                o_instr_ready = 1'b1;
                o_cmd.capture = i_instr_valid;
            end
            ST_DISPATCH: begin
                unique case (i_sts.op) inside
                    OP_LOAD, OP_CLEAR, OP_ADD, OP_SUB: begin
                        o_cmd.wr_alu = 1'b1;
                    end
                    OP_MUL: begin
                        o_cmd.iter_start = 1'b1;
                    end
                    OP_DIV: begin
                        if (!i_sts.div_zero) begin
                            o_cmd.iter_start = 1'b1;
                        end else begin
                            o_cmd.out_load = !i_sts.out_busy;
                            o_cmd.out_kind = KIND_DIV_ZERO;
                        end
                    end
                    OP_PRINT: begin
                        o_cmd.out_load = !i_sts.out_busy;
                        o_cmd.out_kind = KIND_PRINT;
                    end
                    OP_INVALID: begin
                        o_cmd.out_load = !i_sts.out_busy;
                        o_cmd.out_kind = KIND_BAD_OP;
                    end
                endcase
            end
            ST_ITER: begin
                o_cmd.iter_en = 1'b1;
            end
            ST_FINISH: begin
                o_cmd.wr_iter = 1'b1;
            end
            ST_HALT: begin
                // drop every instruction until reset
                o_instr_ready = 1'b1;
            end
        endcase
    end

endmodule

[hdl/rfai_dp.sv]
// ============================================================================
// rfai_dp - register file, ALU, iterative multiply/divide and result register
// Register file with two registered read ports and one write port, a
// one-bit-per-cycle shift-add / restoring-divide unit, and the output stage.
// ============================================================================
module rfai_dp #(
    parameter int NUM_REGS   = rfai_pkg::DEF_NUM_REGS,
    parameter int DATA_WIDTH = rfai_pkg::DEF_DATA_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [rfai_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [rfai_pkg::IDX_W-1:0]     i_src_a,
    input  logic [rfai_pkg::IDX_W-1:0]     i_src_b,
    input  logic [rfai_pkg::IDX_W-1:0]     i_dest,
    input  logic [rfai_pkg::IMM_W-1:0]     i_immediate,
    input  rfai_pkg::t_dp_cmd              i_cmd,
    output rfai_pkg::t_dp_sts              o_sts,
    rfai_result_if.source                  o_result
);
    import rfai_pkg::*;

    localparam int RegIdxW = $clog2(NUM_REGS);
    localparam int SelW    = RegIdxW + IDX_W;
    localparam int CntW    = $clog2(DATA_WIDTH);
    localparam logic [CntW-1:0] CntLast = CntW'(DATA_WIDTH - 1);

    // Fold a 3-bit register field into range; at most four subtracts.
    function automatic logic [RegIdxW-1:0] reg_sel(input logic [IDX_W-1:0] f);
        logic [SelW-1:0] v;
        v = {{RegIdxW{1'b0}}, f};
        for (int i = 0; i < 4; i++) begin
            if (v >= SelW'(NUM_REGS)) begin
                v = v - SelW'(NUM_REGS);
            end
        end
        return v[RegIdxW-1:0];
    endfunction

    function automatic logic [DATA_WIDTH-1:0] abs_val(input logic [DATA_WIDTH-1:0] x);
        return x[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - x) : x;
    endfunction

    // Register file storage and per-entry valid bits (unwritten reads as zero)
    logic [DATA_WIDTH-1:0] r_mem [NUM_REGS];
    logic [NUM_REGS-1:0]   r_valid;

    // Captured instruction
    t_opcode               r_op;
    logic [RegIdxW-1:0]    r_d;
    logic [RegIdxW-1:0]    r_b;
    logic [IMM_W-1:0]      r_imm;
    logic [DATA_WIDTH-1:0] r_va;
    logic [DATA_WIDTH-1:0] r_vb;

    // Iterative unit
    logic [DATA_WIDTH-1:0] r_acc;
    logic [DATA_WIDTH-1:0] r_q;
    logic [DATA_WIDTH-1:0] r_m;
    logic                  r_neg;
    logic [CntW-1:0]       r_cnt;

    // Result register
    logic                  r_out_valid;
    t_kind                 r_kind;
    logic [IDX_W-1:0]      r_idx;
    logic [VAL_W-1:0]      r_val;

    logic [RegIdxW-1:0]    rd_a;
    logic [RegIdxW-1:0]    rd_b;
    logic [RegIdxW-1:0]    sel_d;
    logic                  wr_en;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] alu_res;
    logic [DATA_WIDTH-1:0] iter_res;
    logic [DATA_WIDTH-1:0] imm_fit;
    logic [DATA_WIDTH+IMM_W-1:0] imm_ext;
    logic [DATA_WIDTH+VAL_W-1:0] va_ext;
    logic [SelW-1:0]       d_ext;
    logic [DATA_WIDTH-1:0] shifted;
    logic [DATA_WIDTH-1:0] mul_next;

    // Read addresses; print reads its register on port A
    assign sel_d = reg_sel(i_dest);
    assign rd_a  = (t_opcode'(i_opcode) == OP_PRINT) ? sel_d : reg_sel(i_src_a);
    assign rd_b  = reg_sel(i_src_b);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= t_opcode'(i_opcode);
            r_d   <= sel_d;
            r_b   <= rd_b;
            r_imm <= i_immediate;
            r_va  <= r_valid[rd_a] ? r_mem[rd_a] : '0;
            r_vb  <= r_valid[rd_b] ? r_mem[rd_b] : '0;
        end
    end

    // Combinational ALU
    assign imm_ext = {{DATA_WIDTH{r_imm[IMM_W-1]}}, r_imm};
    assign imm_fit = imm_ext[DATA_WIDTH-1:0];

    always_comb begin
        case (r_op)
            OP_LOAD: alu_res = imm_fit;
            OP_ADD:  alu_res = r_va + r_vb;
            OP_SUB:  alu_res = r_va - r_vb;
            default: alu_res = '0;
        endcase
    end

    assign iter_res = (r_op == OP_MUL) ? r_acc
                    : (r_neg ? (DATA_WIDTH'(0) - r_q) : r_q);

    assign wr_en   = i_cmd.wr_alu | i_cmd.wr_iter;
    assign wr_data = i_cmd.wr_iter ? iter_res : alu_res;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_d] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[r_d] <= 1'b1;
        end
    end

    // Iterative unit: MSB-first shift-add multiply or restoring divide
    assign shifted  = {r_acc[DATA_WIDTH-2:0], r_q[DATA_WIDTH-1]};
    assign mul_next = {r_acc[DATA_WIDTH-2:0], 1'b0} + (r_q[DATA_WIDTH-1] ? r_m : '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.iter_start) begin
            r_acc <= '0;
            r_cnt <= '0;
            r_neg <= r_va[DATA_WIDTH-1] ^ r_vb[DATA_WIDTH-1];
            if (r_op == OP_MUL) begin
                r_q <= r_va;
                r_m <= r_vb;
            end else begin
                r_q <= abs_val(r_va);
                r_m <= abs_val(r_vb);
            end
        end else if (i_cmd.iter_en) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_op == OP_MUL) begin
                r_acc <= mul_next;
                r_q   <= {r_q[DATA_WIDTH-2:0], 1'b0};
            end else if (shifted >= r_m) begin
                r_acc <= shifted - r_m;
                r_q   <= {r_q[DATA_WIDTH-2:0], 1'b1};
            end else begin
                r_acc <= shifted;
                r_q   <= {r_q[DATA_WIDTH-2:0], 1'b0};
            end
        end
    end

    // Result register
    assign va_ext = {{VAL_W{1'b0}}, r_va};
    assign d_ext  = {{IDX_W{1'b0}}, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_kind <= i_cmd.out_kind;
            case (i_cmd.out_kind)
                KIND_PRINT: begin
                    r_idx <= d_ext[IDX_W-1:0];
                    r_val <= va_ext[VAL_W-1:0];
                end
                KIND_DIV_ZERO: begin
                    r_idx <= IDX_W'({{IDX_W{1'b0}}, r_b});
                    r_val <= '0;
                end
                default: begin
                    r_idx <= '0;
                    r_val <= '0;
                end
            endcase
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.kind      = r_kind;
    assign o_result.reg_index = r_idx;
    assign o_result.value     = r_val;

    assign o_sts.op        = r_op;
    assign o_sts.div_zero  = (r_vb == '0);
    assign o_sts.iter_done = (r_cnt == CntLast);
    assign o_sts.out_busy  = r_out_valid;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_top - testbench for register_file_alu_interpreter_core
// Sends instruction transfers with random gaps, keeps a shadow register file
// that mirrors the core, and checks each result transfer against the oldest
// predicted result. The run ends with one error that halts the core, followed
// by instructions that the halted core must drop.
// ============================================================================
module tb_top;
    import rfai_pkg::*;

    localparam int NREGS        = DEF_NUM_REGS;
    localparam int GAP_MAX      = 14;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_ITEMS = 495;
    localparam int HALTED_ITEMS = 30;

    typedef struct packed {
        t_kind            kind;
        logic [IDX_W-1:0] reg_index;
        logic [VAL_W-1:0] value;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    rfai_instr_if  instr_bus ();
    rfai_result_if result_bus ();

    register_file_alu_interpreter_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_instr (instr_bus),
        .o_result(result_bus)
    );

    // Shadow copy of the core state and the results it still owes us
    logic [VAL_W-1:0] shadow_regs [NREGS];
    bit               shadow_halted = 1'b0;
    t_result          pending_results [$];

    int error_count  = 0;
    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;
    int sink_wait    = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the core hangs
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int draw_gap(input bit enabled);
        return enabled ? $urandom_range(0, GAP_MAX) : 0;
    endfunction

    function automatic logic [IDX_W-1:0] rand_index();
        return IDX_W'($urandom_range(0, NREGS - 1));
    endfunction

    // Favor the corners and small values so divides give nontrivial quotients
    function automatic logic [VAL_W-1:0] pick_operand();
        case ($urandom_range(0, 7)) inside
            0:       return {1'b0, {(VAL_W-1){1'b1}}};
            1:       return {1'b1, {(VAL_W-1){1'b0}}};
            2:       return '1;
            [3:5]:   return VAL_W'($urandom_range(0, 64)) - VAL_W'(32);
            default: return VAL_W'($urandom());
        endcase
    endfunction

    // Append one predicted result behind the ones still outstanding
    function automatic void expect_result(input t_result r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Execute one instruction on the shadow registers; queue any result it owes
    function automatic void execute_instr(input t_opcode op,
                                          input logic [IDX_W-1:0] ra, rb, rd,
                                          input logic [IMM_W-1:0] imm);
        int               ia, ib, id;
        logic [VAL_W-1:0] va, vb, mag_a, mag_b, quot;
        if (shadow_halted) return;
        ia = ra % NREGS;
        ib = rb % NREGS;
        id = rd % NREGS;
        va = shadow_regs[ia];
        vb = shadow_regs[ib];
        case (op)
            OP_LOAD:  shadow_regs[id] = imm;
            OP_CLEAR: shadow_regs[id] = '0;
            OP_ADD:   shadow_regs[id] = va + vb;
            OP_SUB:   shadow_regs[id] = va - vb;
            OP_MUL:   shadow_regs[id] = va * vb;
            OP_DIV: begin
                if (vb == '0) begin
                    expect_result(t_result'{KIND_DIV_ZERO, IDX_W'(ib), '0});
                    shadow_halted = 1'b1;
                end else begin
                    // divide magnitudes, then fix the sign; min / -1 wraps to min
                    mag_a = va[VAL_W-1] ? -va : va;
                    mag_b = vb[VAL_W-1] ? -vb : vb;
                    quot  = mag_a / mag_b;
                    if (va[VAL_W-1] ^ vb[VAL_W-1]) quot = -quot;
                    shadow_regs[id] = quot;
                end
            end
            OP_PRINT: expect_result(t_result'{KIND_PRINT, IDX_W'(id), shadow_regs[id]});
            default: begin
                expect_result(t_result'{KIND_BAD_OP, '0, '0});
                shadow_halted = 1'b1;
            end
        endcase
    endfunction

    // Drive one instruction and hold it until the core takes it. Valid is only
    // dropped when a gap follows, so back-to-back transfers keep it high.
    task automatic issue_instr(input t_opcode op, input logic [IDX_W-1:0] ra, rb, rd,
                               input logic [IMM_W-1:0] imm);
        int gap;
        gap = draw_gap(src_idle_on);
        if (gap > 0) begin
            instr_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        instr_bus.valid     <= 1'b1;
        instr_bus.opcode    <= op;
        instr_bus.src_a     <= ra;
        instr_bus.src_b     <= rb;
        instr_bus.dest      <= rd;
        instr_bus.immediate <= imm;
        do @(posedge i_clk); while (!instr_bus.ready);
        execute_instr(op, ra, rb, rd, imm);
    endtask

    function automatic void check_field(input string field,
                                        input logic [VAL_W-1:0] want, got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        end
    endfunction

    // Result side: check each transfer against the oldest prediction, then
    // draw how many cycles to stall the next result.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, got kind %0d index %0d value %0h",
                         $time, result_bus.kind, result_bus.reg_index, result_bus.value);
            end else begin
                want = pending_results.pop_front();
                check_field("kind", VAL_W'(want.kind), VAL_W'(result_bus.kind));
                check_field("reg_index", VAL_W'(want.reg_index), VAL_W'(result_bus.reg_index));
                check_field("value", want.value, result_bus.value);
            end
            sink_wait = draw_gap(sink_idle_on);
        end else if (result_bus.valid && sink_wait > 0) begin
            sink_wait--;
        end
        result_bus.ready <= (sink_wait == 0);
    end

    // Registers must read as zero right after reset
    task automatic test_reset_values();
        issue_instr(OP_PRINT, '0, '0, 3'd0, '0);
        issue_instr(OP_PRINT, '1, '1, 3'd7, '1);
    endtask

    // Corners of every operation: wrap on add, subtract and multiply, the
    // min / -1 divide, truncation toward zero, and clear
    task automatic test_directed_alu();
        issue_instr(OP_LOAD,  3'd0, 3'd0, 3'd1, 32'h7FFF_FFFF);
        issue_instr(OP_LOAD,  3'd7, 3'd7, 3'd2, 32'h8000_0000);
        issue_instr(OP_LOAD,  3'd5, 3'd2, 3'd3, 32'hFFFF_FFFF);
        issue_instr(OP_LOAD,  3'd2, 3'd5, 3'd4, 32'd1);
        issue_instr(OP_ADD,   3'd1, 3'd4, 3'd5, '0);
        issue_instr(OP_PRINT, '0,   '0,   3'd5, '0);
        issue_instr(OP_SUB,   3'd2, 3'd4, 3'd6, '0);
        issue_instr(OP_PRINT, '0,   '0,   3'd6, '0);
        issue_instr(OP_MUL,   3'd1, 3'd1, 3'd7, '0);
        issue_instr(OP_PRINT, '0,   '0,   3'd7, '0);
        issue_instr(OP_DIV,   3'd2, 3'd3, 3'd0, '0);
        issue_instr(OP_PRINT, '0,   '0,   3'd0, '0);
        issue_instr(OP_MUL,   3'd2, 3'd3, 3'd6, '0);
        issue_instr(OP_PRINT, '0,   '0,   3'd6, '0);
        issue_instr(OP_LOAD,  '0,   '0,   3'd6, 32'hFFFF_FFF9);
        issue_instr(OP_LOAD,  '0,   '0,   3'd7, 32'd2);
        issue_instr(OP_DIV,   3'd6, 3'd7, 3'd0, '0);
        issue_instr(OP_PRINT, '0,   '0,   3'd0, '0);
        issue_instr(OP_DIV,   3'd7, 3'd6, 3'd5, '0);
        issue_instr(OP_PRINT, '0,   '0,   3'd5, '0);
        issue_instr(OP_CLEAR, '0,   '0,   3'd1, '0);
        issue_instr(OP_PRINT, '0,   '0,   3'd1, '0);
    endtask

    // Random programs that never trip an error, so the core stays live
    task automatic test_random_program(input int n_items);
        t_opcode          op;
        logic [IDX_W-1:0] ra, rb, rd;
        int               pick;
        for (int i = 0; i < n_items; i++) begin
            // switch idling on and off in stretches
            if (i % 64 == 0) begin
                src_idle_on  = ($urandom_range(0, 3) != 0);
                sink_idle_on = ($urandom_range(0, 3) != 0);
            end
            ra   = rand_index();
            rb   = rand_index();
            rd   = rand_index();
            pick = $urandom_range(0, 99);
            if (pick < 20)      op = OP_LOAD;
            else if (pick < 25) op = OP_CLEAR;
            else if (pick < 40) op = OP_ADD;
            else if (pick < 55) op = OP_SUB;
            else if (pick < 67) op = OP_MUL;
            else if (pick < 80) op = OP_DIV;
            else                op = OP_PRINT;
            // steer the divisor to a nonzero register; fall back to a load
            if (op == OP_DIV) begin
                for (int k = 0; k < NREGS && shadow_regs[rb] == '0; k++) rb = rb + 1'b1;
                if (shadow_regs[rb] == '0) op = OP_LOAD;
            end
            issue_instr(op, ra, rb, rd, pick_operand());
        end
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    // Halt the core with one error, then confirm it drops everything after
    task automatic test_halt();
        logic [IDX_W-1:0] zero_reg;
        zero_reg = rand_index();
        if ($urandom_range(0, 1) != 0) begin
            issue_instr(OP_CLEAR, rand_index(), rand_index(), zero_reg, VAL_W'($urandom()));
            issue_instr(OP_DIV, rand_index(), zero_reg, rand_index(), VAL_W'($urandom()));
        end else begin
            issue_instr(OP_INVALID, rand_index(), rand_index(), rand_index(),
                        VAL_W'($urandom()));
        end
        repeat (HALTED_ITEMS)
            issue_instr(t_opcode'($urandom_range(0, 7)), rand_index(), rand_index(),
                        rand_index(), VAL_W'($urandom()));
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        instr_bus.valid      <= 1'b0;
        instr_bus.opcode     <= OP_LOAD;
        instr_bus.src_a      <= '0;
        instr_bus.src_b      <= '0;
        instr_bus.dest       <= '0;
        instr_bus.immediate  <= '0;
        foreach (shadow_regs[r]) shadow_regs[r] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_directed_alu();
        test_random_program(RANDOM_ITEMS);
        test_halt();

        // Drop valid, drain the outstanding results, then watch for strays
        instr_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
